FILE: sv/tprt_pkg.sv
`timescale 1ns / 1ps
package tprt_pkg;

   localparam int CW = 32;         // coordinate width, Q16.16
   localparam int DW = CW + 1;     // exact difference of two coordinates
   localparam int VW = 31;         // difference after shrinking, |v| < 2^30
   localparam int PW = 2 * VW;     // one product of two differences
   localparam int SW = PW + 1;     // dot or cross
   localparam int NW = 31;         // normalized dot and cross
   localparam int KW = 34;         // cordic datapath
   localparam int TW = 32;         // cos and sin, Q2.30
   localparam int MW = 2 * CW;     // trig times coordinate
   localparam int RW = CW + 3;     // rotated coordinate after rounding

   localparam logic signed [63:0] ONE_Q30  = 64'sd1073741824;
   localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;
   localparam logic signed [KW-1:0] INV_GAIN = 34'sd652032874;
   localparam logic signed [KW-1:0] CLIP_HI  = 34'sd1073741824;
   localparam logic signed [KW-1:0] CLIP_LO  = -34'sd1073741824;
   localparam logic signed [TW-1:0] TRIG_ONE = 32'sd1073741824;
   localparam logic signed [63:0] COORD_MAX = 64'sd2147483647;
   localparam logic signed [63:0] COORD_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [CW-1:0] orig_a_x;
      logic signed [CW-1:0] orig_a_y;
      logic signed [CW-1:0] orig_b_x;
      logic signed [CW-1:0] orig_b_y;
      logic signed [CW-1:0] cur_a_x;
      logic signed [CW-1:0] cur_a_y;
      logic signed [CW-1:0] cur_b_x;
      logic signed [CW-1:0] cur_b_y;
      logic signed [CW-1:0] query_x;
      logic signed [CW-1:0] query_y;
   } req_type;

   typedef struct packed {
      logic signed [TW-1:0] cos_theta;
      logic signed [TW-1:0] sin_theta;
      logic signed [CW-1:0] shift_x;
      logic signed [CW-1:0] shift_y;
      logic signed [CW-1:0] mapped_x;
      logic signed [CW-1:0] mapped_y;
   } rsp_type;

   // points that ride along with the angle computation
   typedef struct packed {
      logic signed [CW-1:0] oax;
      logic signed [CW-1:0] oay;
      logic signed [CW-1:0] cax;
      logic signed [CW-1:0] cay;
      logic signed [CW-1:0] qx;
      logic signed [CW-1:0] qy;
   } side_type;

   typedef struct packed {
      logic signed [VW-1:0] a;
      logic signed [VW-1:0] b;
   } vpair_type;

   typedef struct packed {
      logic                 zero;
      logic signed [KW-1:0] x;
      logic signed [KW-1:0] y;
      logic signed [KW-1:0] c;
      logic signed [KW-1:0] s;
      side_type             side;
   } cin_type;

   typedef struct packed {
      logic signed [TW-1:0] c;
      logic signed [TW-1:0] s;
      side_type             side;
   } trig_type;

   function automatic logic fits_q30(input logic signed [63:0] v);
      return (v > -ONE_Q30) && (v < ONE_Q30);
   endfunction

   function automatic logic fits_q29(input logic signed [63:0] v);
      return (v > -HALF_Q30) && (v < HALF_Q30);
   endfunction

   // smallest common floor shift that brings both below 2^30 in magnitude
   function automatic vpair_type shrink_diff(input logic signed [DW-1:0] a,
                                             input logic signed [DW-1:0] b);
      vpair_type r;
      logic signed [63:0] aw;
      logic signed [63:0] bw;
      aw = 64'(a);
      bw = 64'(b);
      r.a = VW'(aw >>> 3);
      r.b = VW'(bw >>> 3);
      for (int k = 2; k >= 0; k--) begin
         if (fits_q30(aw >>> k) && fits_q30(bw >>> k)) begin
            r.a = VW'(aw >>> k);
            r.b = VW'(bw >>> k);
         end
      end
      return r;
   endfunction

   function automatic logic signed [CW-1:0] sat_coord(input logic signed [63:0] v);
      if (v > COORD_MAX) begin
         return CW'(COORD_MAX);
      end else if (v < COORD_MIN) begin
         return CW'(COORD_MIN);
      end
      return CW'(v);
   endfunction

endpackage

FILE: sv/tprt_vecnorm.sv
`timescale 1ns / 1ps
module tprt_vecnorm (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  tprt_pkg::req_type in_data,
   output logic              out_valid,
   output tprt_pkg::cin_type out_data
);
   import tprt_pkg::*;

   // stage 1: shrunk difference vectors
   logic                 v1_ff;
   logic signed [VW-1:0] dox_ff, doy_ff, dcx_ff, dcy_ff;
   side_type             side1_ff;
   vpair_type            do_in, dc_in;
   side_type             side_in;

   // stage 2: products
   logic                 v2_ff;
   logic signed [PW-1:0] pxx_ff, pyy_ff, pyx_ff, pxy_ff;
   side_type             side2_ff;

   // stage 3: dot and cross
   logic                 v3_ff;
   logic signed [SW-1:0] dot_ff, cross_ff;
   logic                 zero3_ff;
   side_type             side3_ff;

   // stages 4 and 5: right scaling in two halves
   logic                 v4_ff;
   logic signed [SW-1:0] a4_ff, b4_ff, a4_in, b4_in;
   logic                 zero4_ff;
   side_type             side4_ff;

   logic                 v5_ff;
   logic signed [NW-1:0] a5_ff, b5_ff, a5_in, b5_in;
   logic                 zero5_ff;
   side_type             side5_ff;

   // stage 6: left scaling and cordic start vector
   logic                 v6_ff;
   cin_type              cin_ff, cin_in;

   always_comb begin
      do_in = shrink_diff(DW'(in_data.orig_b_x) - DW'(in_data.orig_a_x),
                          DW'(in_data.orig_b_y) - DW'(in_data.orig_a_y));
      dc_in = shrink_diff(DW'(in_data.cur_b_x) - DW'(in_data.cur_a_x),
                          DW'(in_data.cur_b_y) - DW'(in_data.cur_a_y));
      side_in.oax = in_data.orig_a_x;
      side_in.oay = in_data.orig_a_y;
      side_in.cax = in_data.cur_a_x;
      side_in.cay = in_data.cur_a_y;
      side_in.qx  = in_data.query_x;
      side_in.qy  = in_data.query_y;
   end

   // binary search for the floor shift, top half
   always_comb begin
      a4_in = dot_ff;
      b4_in = cross_ff;
      for (int j = 5; j >= 3; j--) begin
         if (!(fits_q30(64'(a4_in >>> ((1 << j) - 1))) &&
               fits_q30(64'(b4_in >>> ((1 << j) - 1))))) begin
            a4_in = a4_in >>> (1 << j);
            b4_in = b4_in >>> (1 << j);
         end
      end
   end

   always_comb begin
      logic signed [SW-1:0] a, b;
      a = a4_ff;
      b = b4_ff;
      for (int j = 2; j >= 0; j--) begin
         if (!(fits_q30(64'(a >>> ((1 << j) - 1))) &&
               fits_q30(64'(b >>> ((1 << j) - 1))))) begin
            a = a >>> (1 << j);
            b = b >>> (1 << j);
         end
      end
      a5_in = NW'(a);
      b5_in = NW'(b);
   end

   // grow until the larger magnitude reaches 2^29, then fold into the right half plane
   always_comb begin
      logic signed [63:0] aw, bw;
      aw = 64'(a5_ff);
      bw = 64'(b5_ff);
      for (int j = 4; j >= 0; j--) begin
         if (fits_q29(aw <<< ((1 << j) - 1)) && fits_q29(bw <<< ((1 << j) - 1))) begin
            aw = aw <<< (1 << j);
            bw = bw <<< (1 << j);
         end
      end
      cin_in.zero = zero5_ff;
      cin_in.s    = '0;
      cin_in.side = side5_ff;
      if (aw < 0) begin
         cin_in.x = KW'(-aw);
         cin_in.y = KW'(-bw);
         cin_in.c = -INV_GAIN;
      end else begin
         cin_in.x = KW'(aw);
         cin_in.y = KW'(bw);
         cin_in.c = INV_GAIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dox_ff   <= do_in.a;
         doy_ff   <= do_in.b;
         dcx_ff   <= dc_in.a;
         dcy_ff   <= dc_in.b;
         side1_ff <= side_in;

         pxx_ff   <= dcx_ff * dox_ff;
         pyy_ff   <= dcy_ff * doy_ff;
         pyx_ff   <= dcy_ff * dox_ff;
         pxy_ff   <= dcx_ff * doy_ff;
         side2_ff <= side1_ff;

         dot_ff   <= SW'(pxx_ff) + SW'(pyy_ff);
         cross_ff <= SW'(pyx_ff) - SW'(pxy_ff);
         zero3_ff <= (pxx_ff == -pyy_ff) && (pyx_ff == pxy_ff);
         side3_ff <= side2_ff;

         a4_ff    <= a4_in;
         b4_ff    <= b4_in;
         zero4_ff <= zero3_ff;
         side4_ff <= side3_ff;

         a5_ff    <= a5_in;
         b5_ff    <= b5_in;
         zero5_ff <= zero4_ff;
         side5_ff <= side4_ff;

         cin_ff   <= cin_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_data  = cin_ff;

endmodule

FILE: sv/tprt_cordic.sv
`timescale 1ns / 1ps
module tprt_cordic #(
   parameter int STAGES = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  tprt_pkg::cin_type  in_data,
   output logic               out_valid,
   output tprt_pkg::trig_type out_data
);
   import tprt_pkg::*;

   logic     valid_ff [STAGES];
   cin_type  stage_ff [STAGES];
   logic     out_valid_ff;
   trig_type out_ff, out_in;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic    cur_valid;
      cin_type cur, nxt;

      if (i == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur       = in_data;
      end else begin : g_rest
         assign cur_valid = valid_ff[i-1];
         assign cur       = stage_ff[i-1];
      end

      // vector turns toward the x axis, unit vector turns the other way
      always_comb begin
         nxt = cur;
         if (cur.y >= 0) begin
            nxt.x = cur.x + (cur.y >>> i);
            nxt.y = cur.y - (cur.x >>> i);
            nxt.c = cur.c - (cur.s >>> i);
            nxt.s = cur.s + (cur.c >>> i);
         end else begin
            nxt.x = cur.x - (cur.y >>> i);
            nxt.y = cur.y + (cur.x >>> i);
            nxt.c = cur.c + (cur.s >>> i);
            nxt.s = cur.s - (cur.c >>> i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[i] <= nxt;
         end
      end
   end

   always_comb begin
      cin_type last;
      last = stage_ff[STAGES-1];
      out_in.side = last.side;
      if (last.zero) begin
         out_in.c = TRIG_ONE;
         out_in.s = '0;
      end else begin
         if (last.c > CLIP_HI) begin
            out_in.c = TW'(CLIP_HI);
         end else if (last.c < CLIP_LO) begin
            out_in.c = TW'(CLIP_LO);
         end else begin
            out_in.c = TW'(last.c);
         end
         if (last.s > CLIP_HI) begin
            out_in.s = TW'(CLIP_HI);
         end else if (last.s < CLIP_LO) begin
            out_in.s = TW'(CLIP_LO);
         end else begin
            out_in.s = TW'(last.s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

FILE: sv/tprt_xform.sv
`timescale 1ns / 1ps
module tprt_xform (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  tprt_pkg::trig_type in_data,
   output logic               out_valid,
   output tprt_pkg::rsp_type  out_data
);
   import tprt_pkg::*;

   // stage 1: eight products
   logic                 v1_ff;
   logic signed [MW-1:0] coa_x_ff, soa_y_ff, soa_x_ff, coa_y_ff;
   logic signed [MW-1:0] cq_x_ff, sq_y_ff, sq_x_ff, cq_y_ff;
   logic signed [TW-1:0] c1_ff, s1_ff;
   logic signed [CW-1:0] cax1_ff, cay1_ff;

   // stage 2: rounded rotations
   logic                 v2_ff;
   logic signed [RW-1:0] rox_ff, roy_ff, rqx_ff, rqy_ff;
   logic signed [RW-1:0] rox_in, roy_in, rqx_in, rqy_in;
   logic signed [TW-1:0] c2_ff, s2_ff;
   logic signed [CW-1:0] cax2_ff, cay2_ff;

   logic signed [RW:0]   tx, ty;
   logic signed [RW+1:0] mx, my;

   // floor((sum + 2^29) / 2^30)
   always_comb begin
      rox_in = RW'(((MW+1)'(coa_x_ff) - (MW+1)'(soa_y_ff) + (MW+1)'(HALF_Q30)) >>> 30);
      roy_in = RW'(((MW+1)'(soa_x_ff) + (MW+1)'(coa_y_ff) + (MW+1)'(HALF_Q30)) >>> 30);
      rqx_in = RW'(((MW+1)'(cq_x_ff) - (MW+1)'(sq_y_ff) + (MW+1)'(HALF_Q30)) >>> 30);
      rqy_in = RW'(((MW+1)'(sq_x_ff) + (MW+1)'(cq_y_ff) + (MW+1)'(HALF_Q30)) >>> 30);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coa_x_ff <= in_data.c * in_data.side.oax;
         soa_y_ff <= in_data.s * in_data.side.oay;
         soa_x_ff <= in_data.s * in_data.side.oax;
         coa_y_ff <= in_data.c * in_data.side.oay;
         cq_x_ff  <= in_data.c * in_data.side.qx;
         sq_y_ff  <= in_data.s * in_data.side.qy;
         sq_x_ff  <= in_data.s * in_data.side.qx;
         cq_y_ff  <= in_data.c * in_data.side.qy;
         c1_ff    <= in_data.c;
         s1_ff    <= in_data.s;
         cax1_ff  <= in_data.side.cax;
         cay1_ff  <= in_data.side.cay;

         rox_ff   <= rox_in;
         roy_ff   <= roy_in;
         rqx_ff   <= rqx_in;
         rqy_ff   <= rqy_in;
         c2_ff    <= c1_ff;
         s2_ff    <= s1_ff;
         cax2_ff  <= cax1_ff;
         cay2_ff  <= cay1_ff;
      end
   end

   // translation stays wide; only the outputs saturate
   assign tx = (RW+1)'(cax2_ff) - (RW+1)'(rox_ff);
   assign ty = (RW+1)'(cay2_ff) - (RW+1)'(roy_ff);
   assign mx = (RW+2)'(rqx_ff) + (RW+2)'(tx);
   assign my = (RW+2)'(rqy_ff) + (RW+2)'(ty);

   always_comb begin
      out_data.cos_theta = c2_ff;
      out_data.sin_theta = s2_ff;
      out_data.shift_x   = sat_coord(64'(tx));
      out_data.shift_y   = sat_coord(64'(ty));
      out_data.mapped_x  = sat_coord(64'(mx));
      out_data.mapped_y  = sat_coord(64'(my));
   end

   assign out_valid = v2_ff;

endmodule

FILE: sv/two_point_rigid_transform.sv
`timescale 1ns / 1ps
// depth: vecnorm, one stage per cordic iteration plus output reg, xform, rsp register
// throughput: one beat per cycle while the skid register is empty
// a skid register lets one more beat leave the pipeline while rsp waits
// reset: synchronous, active high; clears all valid bits, no state is kept between beats
module two_point_rigid_transform #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tprt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tprt_pkg::rsp_type rsp_data
);
   import tprt_pkg::*;

   logic     en;
   logic     norm_valid, trig_valid, last_valid;
   cin_type  norm_data;
   trig_type trig_data;
   rsp_type  last_data;

   logic     rsp_valid_ff, skid_valid_ff;
   rsp_type  rsp_data_ff, skid_data_ff;
   logic     load;

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   tprt_vecnorm u_vecnorm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (norm_valid),
      .out_data  (norm_data)
   );

   tprt_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (norm_valid),
      .in_data   (norm_data),
      .out_valid (trig_valid),
      .out_data  (trig_data)
   );

   tprt_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (trig_valid),
      .in_data   (trig_data),
      .out_valid (last_valid),
      .out_data  (last_data)
   );

   assign load = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (load) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= last_valid;
         end
      end else if (last_valid && en) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : last_data;
      end else if (en) begin
         skid_data_ff <= last_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/tb_two_point_rigid_transform.sv
`timescale 1ns / 1ps
module tb_two_point_rigid_transform;
   import tprt_pkg::*;

   localparam int LATENCY = 34;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_degenerate = 0;
   int n_saturated = 0;
   bit rsp_idle_enable = 1;
   int rsp_hold = 0;

   two_point_rigid_transform dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   typedef logic signed [63:0] s64;

   function automatic s64 abs_s64(input s64 v);
      return v < 0 ? -v : v;
   endfunction

   function automatic s64 sat_out(input s64 v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // 128-bit exact sum, rounded half up after dropping 30 bits
   function automatic s64 rotate_round(input s64 k1, input s64 a, input s64 k2, input s64 b);
      logic signed [127:0] acc;
      acc = 128'(k1) * 128'(a) + 128'(k2) * 128'(b) + 128'(64'sd536870912);
      return s64'(acc >>> 30);
   endfunction

   function automatic void shrink_to_q30(inout s64 a, inout s64 b);
      while (abs_s64(a) >= 64'sd1073741824 || abs_s64(b) >= 64'sd1073741824) begin
         a = a >>> 1;
         b = b >>> 1;
      end
   endfunction

   function automatic rsp_type predict_transform(input req_type r, output bit degenerate);
      rsp_type o;
      s64 dox, doy, dcx, dcy, dot, crs, c, s, x, y, xs, ys, cs, ss, tx, ty, mx, my;
      dox = s64'(r.orig_b_x) - s64'(r.orig_a_x);
      doy = s64'(r.orig_b_y) - s64'(r.orig_a_y);
      dcx = s64'(r.cur_b_x) - s64'(r.cur_a_x);
      dcy = s64'(r.cur_b_y) - s64'(r.cur_a_y);
      shrink_to_q30(dox, doy);
      shrink_to_q30(dcx, dcy);
      dot = dcx * dox + dcy * doy;
      crs = dcy * dox - dcx * doy;
      degenerate = (dot == 0 && crs == 0);
      if (degenerate) begin
         c = 64'sd1073741824;
         s = 0;
      end else begin
         shrink_to_q30(dot, crs);
         while (abs_s64(dot) < 64'sd536870912 && abs_s64(crs) < 64'sd536870912) begin
            dot = dot * 2;
            crs = crs * 2;
         end
         if (dot < 0) begin
            x = -dot; y = -crs; c = -64'sd652032874;
         end else begin
            x = dot; y = crs; c = 64'sd652032874;
         end
         s = 0;
         for (int i = 0; i < 24; i++) begin
            xs = x >>> i; ys = y >>> i; cs = c >>> i; ss = s >>> i;
            if (y >= 0) begin
               x += ys; y -= xs; c -= ss; s += cs;
            end else begin
               x -= ys; y += xs; c += ss; s -= cs;
            end
         end
         if (c > 64'sd1073741824) c = 64'sd1073741824;
         if (c < -64'sd1073741824) c = -64'sd1073741824;
         if (s > 64'sd1073741824) s = 64'sd1073741824;
         if (s < -64'sd1073741824) s = -64'sd1073741824;
      end
      tx = s64'(r.cur_a_x) - rotate_round(c, s64'(r.orig_a_x), -s, s64'(r.orig_a_y));
      ty = s64'(r.cur_a_y) - rotate_round(s, s64'(r.orig_a_x), c, s64'(r.orig_a_y));
      mx = rotate_round(c, s64'(r.query_x), -s, s64'(r.query_y)) + tx;
      my = rotate_round(s, s64'(r.query_x), c, s64'(r.query_y)) + ty;
      o.cos_theta = 32'(c);
      o.sin_theta = 32'(s);
      o.shift_x = 32'(sat_out(tx));
      o.shift_y = 32'(sat_out(ty));
      o.mapped_x = 32'(sat_out(mx));
      o.mapped_y = 32'(sat_out(my));
      if (sat_out(tx) != tx || sat_out(ty) != ty || sat_out(mx) != mx || sat_out(my) != my)
         n_saturated++;
      return o;
   endfunction

   class transform_scoreboard;
      rsp_type pending[$];

      function void note_request(input req_type r);
         bit degenerate;
         rsp_type want;
         want = predict_transform(r, degenerate);
         pending = {pending, want};
         if (degenerate) n_degenerate++;
      endfunction

      function void check_response(input rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected rsp beat %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         n_checked++;
         if (got.cos_theta !== want.cos_theta) begin
            $display("%0t: cos_theta expected %0d actual %0d", $time, want.cos_theta,
               got.cos_theta);
            errors++;
         end
         if (got.sin_theta !== want.sin_theta) begin
            $display("%0t: sin_theta expected %0d actual %0d", $time, want.sin_theta,
               got.sin_theta);
            errors++;
         end
         if (got.shift_x !== want.shift_x) begin
            $display("%0t: shift_x expected %0d actual %0d", $time, want.shift_x, got.shift_x);
            errors++;
         end
         if (got.shift_y !== want.shift_y) begin
            $display("%0t: shift_y expected %0d actual %0d", $time, want.shift_y, got.shift_y);
            errors++;
         end
         if (got.mapped_x !== want.mapped_x) begin
            $display("%0t: mapped_x expected %0d actual %0d", $time, want.mapped_x,
               got.mapped_x);
            errors++;
         end
         if (got.mapped_y !== want.mapped_y) begin
            $display("%0t: mapped_y expected %0d actual %0d", $time, want.mapped_y,
               got.mapped_y);
            errors++;
         end
      endfunction
   endclass

   transform_scoreboard board = new();

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_data);
         if (rsp_valid && rsp_ready) board.check_response(rsp_data);
      end
   end

   // receiver: random stall bursts, or a long hold when asked
   initial begin
      int gap;
      rsp_ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold > 0) begin
            rsp_ready <= 0;
            repeat (rsp_hold) @(negedge clock);
            rsp_hold = 0;
         end else if (rsp_idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_ready <= 1;
            @(negedge clock);
         end
      end
   end

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff - $urandom_range(0, 3);
         1: return 32'sh80000000 + $urandom_range(0, 3);
         2: return 32'sd0;
         3, 4: return 32'($urandom);
         default: return 32'(int'($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
      endcase
   endfunction

   function automatic req_type random_item();
      req_type r;
      int ang;
      s64 cval, sval, dx, dy;
      r.orig_a_x = pick_coord(); r.orig_a_y = pick_coord();
      r.orig_b_x = pick_coord(); r.orig_b_y = pick_coord();
      r.query_x = pick_coord(); r.query_y = pick_coord();
      r.cur_a_x = pick_coord(); r.cur_a_y = pick_coord();
      if ($urandom_range(0, 3) != 0) begin
         // mostly the reference pair turned by a quarter-turn multiple at half its length
         ang = $urandom_range(0, 3);
         dx = s64'(r.orig_b_x) - s64'(r.orig_a_x);
         dy = s64'(r.orig_b_y) - s64'(r.orig_a_y);
         dx = dx >>> 1; dy = dy >>> 1;
         case (ang)
            0: begin cval = dx; sval = dy; end
            1: begin cval = -dy; sval = dx; end
            2: begin cval = -dx; sval = -dy; end
            default: begin cval = dy; sval = -dx; end
         endcase
         r.cur_b_x = 32'(s64'(r.cur_a_x) + cval + $urandom_range(0, 7));
         r.cur_b_y = 32'(s64'(r.cur_a_y) + sval - $urandom_range(0, 7));
      end else begin
         r.cur_b_x = pick_coord(); r.cur_b_y = pick_coord();
      end
      if ($urandom_range(0, 29) == 0) begin
         r.orig_b_x = r.orig_a_x; r.orig_b_y = r.orig_a_y;
      end
      return r;
   endfunction

   task automatic send_item(input req_type r, input bit allow_idle);
      int gap;
      if (allow_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   function automatic req_type make_item(input int ax, input int ay, input int bx,
      input int by, input int cax, input int cay, input int cbx, input int cby,
      input int qx, input int qy);
      req_type r;
      r.orig_a_x = ax; r.orig_a_y = ay; r.orig_b_x = bx; r.orig_b_y = by;
      r.cur_a_x = cax; r.cur_a_y = cay; r.cur_b_x = cbx; r.cur_b_y = cby;
      r.query_x = qx; r.query_y = qy;
      return r;
   endfunction

   localparam int MX = 32'h7fffffff;
   localparam int MN = 32'h80000000;
   localparam int ONE = 32'h00010000;

   initial begin
      req_type r;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: identity, quarter turns, half turn, degenerate, extremes
      send_item(make_item(0, 0, ONE, 0, 0, 0, ONE, 0, 5 * ONE, -3 * ONE), 0);
      send_item(make_item(0, 0, ONE, 0, 0, 0, 0, ONE, ONE, ONE), 0);
      send_item(make_item(0, 0, ONE, 0, 0, 0, -ONE, 0, ONE, 2 * ONE), 0);
      send_item(make_item(0, 0, ONE, 0, 0, 0, 0, -ONE, -ONE, ONE), 0);
      send_item(make_item(ONE, ONE, 3 * ONE, 2 * ONE, 7 * ONE, -ONE, 8 * ONE, ONE, 0, 0), 0);
      send_item(make_item(ONE, ONE, ONE, ONE, 4 * ONE, 4 * ONE, 9, 9, ONE, 0), 0);
      send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_item(make_item(ONE, 0, 2 * ONE, 0, 0, 0, 0, 0, ONE, ONE), 0);
      send_item(make_item(MN, MN, MX, MX, MX, MN, MN, MX, MX, MX), 0);
      send_item(make_item(MX, MX, MN, MN, MN, MN, MX, MX, MN, MN), 0);
      send_item(make_item(MN, 0, MX, 0, MX, MX, MN, MN, MX, MN), 0);
      send_item(make_item(0, MN, 0, MX, MN, MX, MX, MN, MN, MX), 0);
      send_item(make_item(-1, -1, 1, 1, -1, -1, 1, 1, -1, -1), 0);
      send_item(make_item(0, 0, MX, 1, MX, MX, MX, MX - 1, MX, MX), 0);
      send_item(make_item(0, 0, 1, 0, MN, MN, MN, MN + 1, MN, MN), 0);
      send_item(make_item(0, 0, 3, 4, 100, 100, 96, 103, 32'h55555555, 32'haaaaaaaa), 0);
      send_item(make_item(32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa,
         32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
         32'h55555555), 0);

      // sender pauses until all results are back
      drain();

      // receiver holds off long while items keep coming
      rsp_hold = 120;
      for (int i = 0; i < 80; i++) send_item(random_item(), 0);
      drain();

      for (int i = 0; i < 700; i++) send_item(random_item(), 1);
      drain();

      // closing stretch with no idling on either side
      rsp_idle_enable = 0;
      for (int i = 0; i < 170; i++) send_item(random_item(), 0);
      drain();
      repeat (LATENCY + 10) @(negedge clock);

      $display("sent %0d transforms, checked %0d results", n_sent, n_checked);
      $display("degenerate pairs %0d, saturating outputs %0d", n_degenerate, n_saturated);
      if (errors == 0 && board.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout, %0d results outstanding", board.pending.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
sv/tprt_pkg.sv
sv/tprt_vecnorm.sv
sv/tprt_cordic.sv
sv/tprt_xform.sv
sv/two_point_rigid_transform.sv
tb/tb_two_point_rigid_transform.sv
